FILE: src/multi_radix_number_parser_defines.svh
// Assertion macros for the multi-radix number parser.
`ifndef MULTI_RADIX_NUMBER_PARSER_DEFINES_SVH
`define MULTI_RADIX_NUMBER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRNP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRNP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mrnp_pkg.sv
// Package with types and constants of the multi-radix number parser.
`timescale 1ns / 1ps

package mrnp_pkg;

  // Accumulator width; the value output carries the low 32 bits.
  localparam int VALUE_BITS = 32;

  // ASCII codes used by the prefix and digit decoding.
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_ONE   = 8'd49;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UC_A  = 8'd65;
  localparam logic [7:0] CH_UC_F  = 8'd70;
  localparam logic [7:0] HEX_BIAS = 8'd55;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_B     = 8'h62;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_ZERO    = 3'd1,
    PH_HEX     = 3'd2,
    PH_DEC     = 3'd3,
    PH_OCT     = 3'd4,
    PH_BIN     = 3'd5,
    PH_UNKNOWN = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    RK_HEX = 2'd0,
    RK_DEC = 2'd1,
    RK_OCT = 2'd2,
    RK_BIN = 2'd3
  } radix_kind_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_UNKNOWN_PREFIX = 3'd1,
    ST_BAD_HEX        = 3'd2,
    ST_BAD_DEC        = 3'd3,
    ST_DEC_OVERFLOW   = 3'd4
  } status_t;

endpackage

FILE: src/multi_radix_number_parser.sv
// A beat is held in the input register and its result is registered in the result register,
// which raises out_valid once the last character advances out of the input register.
// Throughput: one character per cycle, set by the combinational shift-add of the accumulator.
// A waiting result only holds back a last character; other characters keep flowing.
// Reset (rst, synchronous): parser back to start of string, both stages empty.
`timescale 1ns / 1ps
`include "multi_radix_number_parser_defines.svh"

module multi_radix_number_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic [1:0]  radix_kind,
  output logic [2:0]  status
);

  localparam int VB = mrnp_pkg::VALUE_BITS;

  // Input register
  logic       in_reg_valid;
  logic [7:0] char_reg;
  logic       last_reg;

  // Parser state
  mrnp_pkg::phase_t phase, phase_next;
  logic [VB-1:0]    acc, acc_next;
  logic             overflow_seen, overflow_seen_next;
  logic             bad_char_seen, bad_char_seen_next;
  logic             run_open, run_open_next;

  // Result values
  mrnp_pkg::radix_kind_t kind_res;
  mrnp_pkg::status_t     status_res;
  logic [31:0]           value_res;

  logic advance;

  // Character decode
  logic          is_dec, is_uc_hex;
  logic [7:0]    dec_off, hex_off;
  logic [3:0]    dec_d, hex_d, oct_d;
  logic [VB+3:0] dec_wide;

  // A last character needs the result slot free; others always advance.
  assign advance  = in_reg_valid && (!last_reg || !out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  assign is_dec    = (char_reg >= mrnp_pkg::CH_ZERO) && (char_reg <= mrnp_pkg::CH_NINE);
  assign is_uc_hex = (char_reg >= mrnp_pkg::CH_UC_A) && (char_reg <= mrnp_pkg::CH_UC_F);
  assign dec_off   = char_reg - mrnp_pkg::CH_ZERO;
  assign hex_off   = char_reg - mrnp_pkg::HEX_BIAS;
  assign dec_d     = dec_off[3:0];
  assign hex_d     = is_dec ? dec_d : hex_off[3:0];
  assign oct_d     = is_dec ? dec_d : 4'd0;

  // acc * 10 + digit, wide enough to expose a carry past the value width
  assign dec_wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VB{1'b0}}, dec_d};

  // Next parser state
  always_comb begin
    logic do_dec;
    do_dec             = 1'b0;
    phase_next         = phase;
    acc_next           = acc;
    overflow_seen_next = overflow_seen;
    bad_char_seen_next = bad_char_seen;
    run_open_next      = run_open;
    case (phase)
      mrnp_pkg::PH_START: begin
        if (char_reg == mrnp_pkg::CH_ZERO) begin
          phase_next = mrnp_pkg::PH_ZERO;
        end else if (is_dec) begin
          phase_next = mrnp_pkg::PH_DEC;
          do_dec     = 1'b1;
        end else if (char_reg == mrnp_pkg::CH_O) begin
          phase_next = mrnp_pkg::PH_OCT;
        end else if (char_reg == mrnp_pkg::CH_B) begin
          phase_next = mrnp_pkg::PH_BIN;
        end else begin
          phase_next = mrnp_pkg::PH_UNKNOWN;
        end
      end
      mrnp_pkg::PH_ZERO: begin
        if (char_reg == mrnp_pkg::CH_X) begin
          phase_next = mrnp_pkg::PH_HEX;
        end else begin
          phase_next = mrnp_pkg::PH_DEC;
          do_dec     = 1'b1;
        end
      end
      mrnp_pkg::PH_HEX: begin
        if (is_dec || is_uc_hex) begin
          acc_next = {acc[VB-5:0], hex_d};
        end else begin
          bad_char_seen_next = 1'b1;
        end
      end
      mrnp_pkg::PH_DEC: begin
        do_dec = 1'b1;
      end
      mrnp_pkg::PH_OCT: begin
        // 8 and 9 are taken as digits too
        acc_next = {acc[VB-4:0], 3'b000} + {{(VB-4){1'b0}}, oct_d};
      end
      mrnp_pkg::PH_BIN: begin
        acc_next = {acc[VB-2:0], char_reg == mrnp_pkg::CH_ONE};
      end
      default: begin
        phase_next = mrnp_pkg::PH_UNKNOWN;
      end
    endcase
    // Decimal step: overflow only counts during the leading digit run
    if (do_dec) begin
      if (is_dec) begin
        if (run_open && (dec_wide[VB+3:VB] != 4'd0)) begin
          overflow_seen_next = 1'b1;
        end
        acc_next = dec_wide[VB-1:0];
      end else begin
        run_open_next      = 1'b0;
        bad_char_seen_next = 1'b1;
      end
    end
  end

  // Result of a string ending with this character
  always_comb begin
    kind_res   = mrnp_pkg::RK_HEX;
    status_res = mrnp_pkg::ST_OK;
    case (phase_next)
      mrnp_pkg::PH_HEX: begin
        kind_res   = mrnp_pkg::RK_HEX;
        status_res = bad_char_seen_next ? mrnp_pkg::ST_BAD_HEX : mrnp_pkg::ST_OK;
      end
      mrnp_pkg::PH_ZERO, mrnp_pkg::PH_DEC: begin
        kind_res = mrnp_pkg::RK_DEC;
        if (overflow_seen_next) begin
          status_res = mrnp_pkg::ST_DEC_OVERFLOW;
        end else if (bad_char_seen_next) begin
          status_res = mrnp_pkg::ST_BAD_DEC;
        end else begin
          status_res = mrnp_pkg::ST_OK;
        end
      end
      mrnp_pkg::PH_OCT: begin
        kind_res = mrnp_pkg::RK_OCT;
      end
      mrnp_pkg::PH_BIN: begin
        kind_res = mrnp_pkg::RK_BIN;
      end
      default: begin
        kind_res   = mrnp_pkg::RK_HEX;
        status_res = mrnp_pkg::ST_UNKNOWN_PREFIX;
      end
    endcase
  end

  // Errors report a zero value
  assign value_res = (status_res == mrnp_pkg::ST_OK) ? 32'(acc_next) : 32'd0;

  // Input register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      char_reg <= char_code;
      last_reg <= last_char;
    end
  end

  // Parser state update; a last character returns to start of string
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mrnp_pkg::PH_START;
      acc           <= '0;
      overflow_seen <= 1'b0;
      bad_char_seen <= 1'b0;
      run_open      <= 1'b1;
    end else if (advance) begin
      if (last_reg) begin
        phase         <= mrnp_pkg::PH_START;
        acc           <= '0;
        overflow_seen <= 1'b0;
        bad_char_seen <= 1'b0;
        run_open      <= 1'b1;
      end else begin
        phase         <= phase_next;
        acc           <= acc_next;
        overflow_seen <= overflow_seen_next;
        bad_char_seen <= bad_char_seen_next;
        run_open      <= run_open_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_reg) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && last_reg) begin
      value      <= value_res;
      radix_kind <= kind_res;
      status     <= status_res;
    end
  end

  // Checks
  `MRNP_ASSERT_NOW(a_err_value_zero, out_valid && (status != mrnp_pkg::ST_OK),
                   value == 32'd0, "error result carries a nonzero value")
  `MRNP_ASSERT_NOW(a_unknown_is_hex, out_valid && (status == mrnp_pkg::ST_UNKNOWN_PREFIX),
                   radix_kind == mrnp_pkg::RK_HEX, "unknown prefix with nonzero radix kind")
  `MRNP_ASSERT_NEXT(a_last_restarts, advance && last_reg,
                    (phase == mrnp_pkg::PH_START) && (acc == '0) && out_valid,
                    "last character did not restart the parser")
  `MRNP_ASSERT_NEXT(a_held_beat, in_stall,
                    in_reg_valid && $stable(char_reg) && $stable(last_reg),
                    "held input beat changed")

endmodule

FILE: tb/multi_radix_number_parser_tb.sv
// Testbench for the multi-radix number parser: directed and random strings, checked per result.
`timescale 1ns / 1ps

module multi_radix_number_parser_tb;

  // One character beat waiting to be sent; drain makes the sender wait for all results first
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       drain;
  } char_beat_t;

  // One parsed number as the block should report it
  typedef struct {
    logic [31:0]           value;
    mrnp_pkg::radix_kind_t kind;
    mrnp_pkg::status_t     status;
  } parse_result_t;

  localparam int RANDOM_BEATS = 700;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'd0;
  logic        last_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic [1:0]  radix_kind;
  logic [2:0]  status;

  char_beat_t    pending_chars[$];
  parse_result_t expected_numbers[$];
  logic [7:0]    word_buf[$];

  // Shadow parser state
  mrnp_pkg::phase_t shadow_phase;
  logic [31:0]      shadow_acc;
  logic             shadow_ovf;
  logic             shadow_bad;
  logic             shadow_lead_open;

  int beats_sent = 0;
  int beats_in = 0;
  int total_beats = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_at = 0;
  logic hold_done = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int error_results = 0;
  int kind_count[4];

  logic quiet;
  assign quiet = (beats_sent + 80 >= total_beats);

  multi_radix_number_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .radix_kind(radix_kind),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- shadow parser
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= mrnp_pkg::CH_ZERO) && (c <= mrnp_pkg::CH_NINE);
  endfunction

  function automatic void clear_parser();
    shadow_phase     = mrnp_pkg::PH_START;
    shadow_acc       = 32'd0;
    shadow_ovf       = 1'b0;
    shadow_bad       = 1'b0;
    shadow_lead_open = 1'b1;
  endfunction

  // Decimal digit: overflow is only tracked while the leading digit run is unbroken
  function automatic void take_decimal(input logic [7:0] c);
    logic [31:0] d;
    if (is_digit(c)) begin
      d = 32'(c - mrnp_pkg::CH_ZERO);
      if (shadow_lead_open && shadow_acc > (32'hFFFF_FFFF - d) / 32'd10)
        shadow_ovf = 1'b1;
      shadow_acc = shadow_acc * 32'd10 + d;
    end else begin
      shadow_lead_open = 1'b0;
      shadow_bad       = 1'b1;
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic last);
    parse_result_t r;
    case (shadow_phase)
      mrnp_pkg::PH_START: begin
        if (c == mrnp_pkg::CH_ZERO) shadow_phase = mrnp_pkg::PH_ZERO;
        else if (is_digit(c)) begin
          shadow_phase = mrnp_pkg::PH_DEC;
          take_decimal(c);
        end else if (c == mrnp_pkg::CH_O) shadow_phase = mrnp_pkg::PH_OCT;
        else if (c == mrnp_pkg::CH_B) shadow_phase = mrnp_pkg::PH_BIN;
        else shadow_phase = mrnp_pkg::PH_UNKNOWN;
      end
      mrnp_pkg::PH_ZERO: begin
        if (c == mrnp_pkg::CH_X) shadow_phase = mrnp_pkg::PH_HEX;
        else begin
          shadow_phase = mrnp_pkg::PH_DEC;
          take_decimal(c);
        end
      end
      mrnp_pkg::PH_HEX: begin
        if (is_digit(c)) begin
          shadow_acc = (shadow_acc << 4) | 32'(c - mrnp_pkg::CH_ZERO);
        end else if (c >= mrnp_pkg::CH_UC_A && c <= mrnp_pkg::CH_UC_F) begin
          shadow_acc = (shadow_acc << 4) | 32'(c - mrnp_pkg::HEX_BIAS);
        end else begin
          shadow_bad = 1'b1;
        end
      end
      mrnp_pkg::PH_DEC: take_decimal(c);
      // octal takes 8 and 9 as digits, anything else as zero
      mrnp_pkg::PH_OCT:
        shadow_acc = (shadow_acc << 3) + (is_digit(c) ? 32'(c - mrnp_pkg::CH_ZERO) : 32'd0);
      mrnp_pkg::PH_BIN:
        shadow_acc = (shadow_acc << 1) + ((c == mrnp_pkg::CH_ONE) ? 32'd1 : 32'd0);
      default: shadow_phase = mrnp_pkg::PH_UNKNOWN;
    endcase

    if (last) begin
      r.kind   = mrnp_pkg::RK_HEX;
      r.status = mrnp_pkg::ST_OK;
      case (shadow_phase)
        mrnp_pkg::PH_HEX: r.status = shadow_bad ? mrnp_pkg::ST_BAD_HEX : mrnp_pkg::ST_OK;
        mrnp_pkg::PH_ZERO, mrnp_pkg::PH_DEC: begin
          r.kind = mrnp_pkg::RK_DEC;
          if (shadow_ovf) r.status = mrnp_pkg::ST_DEC_OVERFLOW;
          else if (shadow_bad) r.status = mrnp_pkg::ST_BAD_DEC;
          else r.status = mrnp_pkg::ST_OK;
        end
        mrnp_pkg::PH_OCT: r.kind = mrnp_pkg::RK_OCT;
        mrnp_pkg::PH_BIN: r.kind = mrnp_pkg::RK_BIN;
        default: r.status = mrnp_pkg::ST_UNKNOWN_PREFIX;
      endcase
      r.value = (r.status == mrnp_pkg::ST_OK) ? shadow_acc : 32'd0;
      expected_numbers.push_back(r);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus building
  task automatic flush_word(input logic drain);
    char_beat_t b;
    for (int i = 0; i < word_buf.size(); i++) begin
      b.ch    = word_buf[i];
      b.last  = (i == word_buf.size() - 1);
      b.drain = drain && (i == 0);
      pending_chars.push_back(b);
    end
    word_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
    flush_word(1'b0);
  endtask

  // A dirty word gets some random bytes in place of its well-formed characters
  function automatic logic [7:0] maybe_noise(input logic dirty, input logic [7:0] c);
    if (dirty && $urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic random_word(input logic drain);
    int mode;
    int n;
    int d;
    logic dirty;
    longint unsigned v;
    string s;
    mode  = $urandom_range(0, 9);
    dirty = ($urandom_range(0, 3) == 0);
    case (mode)
      0, 1: begin
        // hex, long enough at times to wrap past 32 bits
        word_buf.push_back(mrnp_pkg::CH_ZERO);
        word_buf.push_back(mrnp_pkg::CH_X);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          d = $urandom_range(0, 15);
          word_buf.push_back(maybe_noise(dirty,
            (d < 10) ? 8'(mrnp_pkg::CH_ZERO + d) : 8'(mrnp_pkg::CH_UC_A + d - 10)));
        end
      end
      2, 3: begin
        if ($urandom_range(0, 3) == 0) begin
          // near the 32-bit ceiling, or a full random 32-bit value
          if ($urandom_range(0, 1) == 0) v = 64'd4294967285 + $urandom_range(0, 20);
          else v = {32'd0, $urandom};
          s = $sformatf("%0d", v);
          for (int i = 0; i < s.len(); i++) word_buf.push_back(maybe_noise(dirty, s[i]));
        end else begin
          n = $urandom_range(1, 12);
          word_buf.push_back(8'(mrnp_pkg::CH_ZERO + $urandom_range(1, 9)));
          for (int i = 1; i < n; i++)
            word_buf.push_back(maybe_noise(dirty, 8'(mrnp_pkg::CH_ZERO + $urandom_range(0, 9))));
        end
      end
      4: begin
        // leading zero followed by decimal digits
        word_buf.push_back(mrnp_pkg::CH_ZERO);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          word_buf.push_back(maybe_noise(dirty, 8'(mrnp_pkg::CH_ZERO + $urandom_range(0, 9))));
      end
      5: begin
        word_buf.push_back(mrnp_pkg::CH_O);
        n = $urandom_range(0, 14);
        for (int i = 0; i < n; i++)
          word_buf.push_back(maybe_noise(dirty, 8'(mrnp_pkg::CH_ZERO + $urandom_range(0, 9))));
      end
      6, 7: begin
        word_buf.push_back(mrnp_pkg::CH_B);
        n = $urandom_range(0, 40);
        for (int i = 0; i < n; i++)
          word_buf.push_back(maybe_noise(dirty, 8'(mrnp_pkg::CH_ZERO + $urandom_range(0, 1))));
      end
      default: begin
        // raw bytes, mostly an unknown prefix
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) word_buf.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    flush_word(drain);
  endtask

  // ---------------------------------------------------------------- sender
  always @(posedge clk) begin
    char_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_char(char_code, last_char);
        beats_in++;
      end
      // a stalled beat keeps its payload; otherwise pick what to offer next
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_chars.size() == 0 ||
                     (pending_chars[0].drain && expected_numbers.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!quiet && ((beats_sent / 64) % 4 != 3) && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 3);
        end else begin
          nb = pending_chars.pop_front();
          in_valid  <= 1'b1;
          char_code <= nb.ch;
          last_char <= nb.last;
          beats_sent++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_in >= hold_at) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- receiver stall
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && ((cycle_cnt / 256) % 4 != 3) && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    parse_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_numbers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result value=%h kind=%0d status=%0d",
                   $realtime, value, radix_kind, status);
      end else begin
        e = expected_numbers.pop_front();
        kind_count[e.kind]++;
        if (e.status != mrnp_pkg::ST_OK) error_results++;
        if (value !== e.value || radix_kind !== e.kind || status !== e.status) begin
          errors++;
          if (errors <= 10)
            $display("%0t: exp value=%h kind=%0d st=%0d, got value=%h kind=%0d st=%0d",
                     $realtime, e.value, e.kind, e.status, value, radix_kind, status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- run control
  initial begin
    int directed_beats;
    int word_idx;
    logic drain_now;
    clear_parser();
    foreach (kind_count[i]) kind_count[i] = 0;

    // directed strings: prefix-only, lone zero, bad hex, raw extremes, overflow over bad digit
    add_text("0");
    add_text("0x");
    add_text("o");
    add_text("b1z");
    add_text("0xFa");
    word_buf.push_back(8'hFF);
    word_buf.push_back(8'h00);
    flush_word(1'b0);
    add_text("07a");
    add_text("5000000000z");
    add_text("o9x");
    directed_beats = pending_chars.size();

    // random strings; two of them wait for the block to drain first
    word_idx = 0;
    while (pending_chars.size() < directed_beats + RANDOM_BEATS) begin
      drain_now = (word_idx == 0) || (word_idx == 70);
      random_word(drain_now);
      word_idx++;
    end
    total_beats = pending_chars.size();
    hold_at     = directed_beats + 250;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_numbers.size() != 0) begin
      errors += expected_numbers.size();
      $display("%0d expected results never arrived", expected_numbers.size());
    end
    $display("Sent %0d characters, checked %0d numbers (%0d error statuses)",
             beats_in, results_seen, error_results);
    $display("Radix mix: hex/unknown %0d, decimal %0d, octal %0d, binary %0d; %0d mismatches",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/mrnp_pkg.sv
src/multi_radix_number_parser.sv
tb/multi_radix_number_parser_tb.sv
